// File: sv/roman_numeral_encoder_assert.svh
// ----------------------------------------------------------------------------
// Roman numeral encoder assertion macros
// Concurrent property wrappers shared by the encoder's assertion block.
// ----------------------------------------------------------------------------
`ifndef ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_ASSERT_SVH

// same-cycle implication
`define RNE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rne assertion failed");

// next-cycle implication
`define RNE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rne assertion failed");

`endif

// File: sv/rne_pkg.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder package
// Symbol codes, microcode word layout, control store and place tables.
// ----------------------------------------------------------------------------
`default_nettype none

package rne_pkg;

    localparam int NUM_W = 14;

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [2:0]       t_sym;
    typedef logic [1:0]       t_phase;
    typedef logic [3:0]       t_digit;
    typedef logic [1:0]       t_cnt;
    typedef logic [2:0]       t_upc;
    typedef logic [1:0]       t_role;
    typedef logic [2:0]       t_cond;

    localparam t_sym SYM_I    = 3'd0;
    localparam t_sym SYM_V    = 3'd1;
    localparam t_sym SYM_X    = 3'd2;
    localparam t_sym SYM_L    = 3'd3;
    localparam t_sym SYM_C    = 3'd4;
    localparam t_sym SYM_D    = 3'd5;
    localparam t_sym SYM_M    = 3'd6;
    localparam t_sym SYM_VBAR = 3'd7;

    localparam t_num LIMIT_HIGH = 14'd9000;
    localparam t_phase PHASE_THOUSANDS = 2'd3;

    localparam t_num PLACE_W [4] = '{14'd1, 14'd10, 14'd100, 14'd1000};

    // symbol roles within one decimal place
    localparam t_role ROLE_ONE  = 2'd0;
    localparam t_role ROLE_FIVE = 2'd1;
    localparam t_role ROLE_TEN  = 2'd2;

    // sequencing conditions
    localparam t_cond COND_DISP = 3'd0;  // extract digit, dispatch
    localparam t_cond COND_SEQ  = 3'd1;  // go to next
    localparam t_cond COND_END  = 3'd2;  // end of digit
    localparam t_cond COND_RUN  = 3'd3;  // count down, end on last
    localparam t_cond COND_FIVE = 3'd4;  // end if no run follows

    // control store addresses
    localparam t_upc UA_EXT    = 3'd0;
    localparam t_upc UA_RUN    = 3'd1;
    localparam t_upc UA_FOUR_A = 3'd2;
    localparam t_upc UA_FOUR_B = 3'd3;
    localparam t_upc UA_FIVE   = 3'd4;
    localparam t_upc UA_NINE_A = 3'd5;
    localparam t_upc UA_NINE_B = 3'd6;

    typedef struct packed {
        logic  emit;
        t_role role;
        t_cond cond;
        t_upc  next;
    } t_uword;

    typedef struct packed {
        t_digit digit;
        t_num   rem;
        t_cnt   run;
    } t_dig;

    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        unique case (upc)
            UA_EXT:    w = '{1'b0, ROLE_ONE,  COND_DISP, UA_EXT};
            UA_RUN:    w = '{1'b1, ROLE_ONE,  COND_RUN,  UA_RUN};
            UA_FOUR_A: w = '{1'b1, ROLE_ONE,  COND_SEQ,  UA_FOUR_B};
            UA_FOUR_B: w = '{1'b1, ROLE_FIVE, COND_END,  UA_EXT};
            UA_FIVE:   w = '{1'b1, ROLE_FIVE, COND_FIVE, UA_RUN};
            UA_NINE_A: w = '{1'b1, ROLE_ONE,  COND_SEQ,  UA_NINE_B};
            UA_NINE_B: w = '{1'b1, ROLE_TEN,  COND_END,  UA_EXT};
            default:   w = '{1'b0, ROLE_ONE,  COND_SEQ,  UA_EXT};
        endcase
        return w;
    endfunction

    function automatic t_upc dispatch(input t_digit d);
        t_upc a;
        unique case (d) inside
            4'd1, 4'd2, 4'd3:         a = UA_RUN;
            4'd4:                     a = UA_FOUR_A;
            4'd5, 4'd6, 4'd7, 4'd8:   a = UA_FIVE;
            4'd9:                     a = UA_NINE_A;
            default:                  a = UA_EXT;
        endcase
        return a;
    endfunction

    function automatic t_sym sym_of(input t_role role, input t_phase p);
        t_sym s;
        unique case ({role, p})
            {ROLE_ONE,  2'd0}: s = SYM_I;
            {ROLE_ONE,  2'd1}: s = SYM_X;
            {ROLE_ONE,  2'd2}: s = SYM_C;
            {ROLE_ONE,  2'd3}: s = SYM_M;
            {ROLE_FIVE, 2'd0}: s = SYM_V;
            {ROLE_FIVE, 2'd1}: s = SYM_L;
            {ROLE_FIVE, 2'd2}: s = SYM_D;
            {ROLE_FIVE, 2'd3}: s = SYM_VBAR;
            {ROLE_TEN,  2'd0}: s = SYM_X;
            {ROLE_TEN,  2'd1}: s = SYM_C;
            {ROLE_TEN,  2'd2}: s = SYM_M;
            {ROLE_TEN,  2'd3}: s = SYM_M;
            default:           s = SYM_I;
        endcase
        return s;
    endfunction

    function automatic t_num place_mult(input t_phase p, input t_digit k);
        t_num w;
        w = PLACE_W[p];
        return NUM_W'(w * NUM_W'(k));
    endfunction

endpackage

`default_nettype wire

// File: sv/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder
// Converts a number to Roman numeral symbols, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_number_in and raise start; the item is taken on a clock
//   edge with start high and busy low. busy stays high while symbols are
//   produced.
//   Output: each symbol appears on o_symbol for one cycle with o_strobe high;
//   o_last_symbol marks the final symbol of the number. The receiver cannot
//   stall, so every strobed symbol must be taken in its cycle.
//   Out of range (0 or 9000 and up): one result, symbol I, last and
//   o_out_of_range set, in the cycle after accept; busy stays low, so a new
//   item may follow on the next edge.
//   Sequencing: a microcoded sequencer splits off the digit of each decimal
//   place (thousands down to the lowest nonzero place) in a step of its own
//   and emits each symbol in a step of its own. The first symbol comes later
//   the more leading zero places there are. Worst case 8888 emits sixteen
//   symbols; no new item is taken until busy falls.
//   Reset: synchronous, active low; clears sequencer and output strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module roman_numeral_encoder (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          start,
    output var logic          busy,
    input  var rne_pkg::t_num i_number_in,
    output var logic          o_strobe,
    output var rne_pkg::t_sym o_symbol,
    output var logic          o_last_symbol,
    output var logic          o_out_of_range
);
    import rne_pkg::*;

    logic   r_busy,   n_busy;
    t_upc   r_upc,    n_upc;
    t_phase r_phase,  n_phase;
    t_num   r_rem,    n_rem;
    t_cnt   r_cnt,    n_cnt;
    logic   r_strobe, n_strobe;
    t_sym   r_sym,    n_sym;
    logic   r_last,   n_last;
    logic   r_oor,    n_oor;

    t_uword uw;
    t_dig   dg;
    logic   end_digit;
    logic   bad_num;

    rne_digit u_digit (
        .i_rem   (r_rem),
        .i_phase (r_phase),
        .o_dig   (dg)
    );

    assign uw      = ucode(r_upc);
    assign bad_num = (i_number_in == '0) || (i_number_in >= LIMIT_HIGH);

    always_comb begin
        n_busy    = r_busy;
        n_upc     = r_upc;
        n_phase   = r_phase;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_sym     = r_sym;
        n_last    = 1'b0;
        n_oor     = 1'b0;
        end_digit = 1'b0;
        if (!r_busy) begin
            if (start) begin
                if (bad_num) begin
                    n_strobe = 1'b1;
                    n_sym    = SYM_I;
                    n_last   = 1'b1;
                    n_oor    = 1'b1;
                end else begin
                    n_busy  = 1'b1;
                    n_rem   = i_number_in;
                    n_phase = PHASE_THOUSANDS;
                    n_upc   = UA_EXT;
                end
            end
        end else begin
            unique case (uw.cond)
                COND_DISP: begin
                    n_rem = dg.rem;
                    n_cnt = dg.run;
                    if (dg.digit == '0) begin
                        n_phase = r_phase - 2'd1;
                    end else begin
                        n_upc = dispatch(dg.digit);
                    end
                end
                COND_SEQ: begin
                    n_upc = uw.next;
                end
                COND_END: begin
                    end_digit = 1'b1;
                end
                COND_RUN: begin
                    n_cnt = r_cnt - 2'd1;
                    if (r_cnt == 2'd1) begin
                        end_digit = 1'b1;
                    end else begin
                        n_upc = uw.next;
                    end
                end
                COND_FIVE: begin
                    if (r_cnt == '0) begin
                        end_digit = 1'b1;
                    end else begin
                        n_upc = uw.next;
                    end
                end
                default: begin
                    n_upc = UA_EXT;
                end
            endcase
            if (uw.emit) begin
                n_strobe = 1'b1;
                n_sym    = sym_of(uw.role, r_phase);
                n_last   = end_digit && (r_rem == '0);
            end
            if (end_digit) begin
                n_upc = UA_EXT;
                if (r_rem == '0) begin
                    n_busy = 1'b0;
                end else begin
                    n_phase = r_phase - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_upc    <= UA_EXT;
            r_phase  <= '0;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_oor    <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_upc    <= n_upc;
            r_phase  <= n_phase;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
            r_last   <= n_last;
            r_oor    <= n_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

    assign busy           = r_busy;
    assign o_strobe       = r_strobe;
    assign o_symbol       = r_sym;
    assign o_last_symbol  = r_last;
    assign o_out_of_range = r_oor;

`include "roman_numeral_encoder_assert.svh"

    `RNE_ASSERT_NOW(a_oor_form, i_clk, i_rst_n, o_out_of_range,
        o_strobe && o_last_symbol && (o_symbol == SYM_I))
    `RNE_ASSERT_NEXT(a_bad_one_result, i_clk, i_rst_n, start && !busy && bad_num,
        o_strobe && o_out_of_range && !busy)
    `RNE_ASSERT_NEXT(a_good_starts_run, i_clk, i_rst_n, start && !busy && !bad_num,
        busy && !o_strobe)
    `RNE_ASSERT_NOW(a_run_ends_last, i_clk, i_rst_n, $fell(busy),
        o_strobe && o_last_symbol && !o_out_of_range)
    `RNE_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_strobe && o_last_symbol, !busy)

endmodule

`default_nettype wire

// File: sv/rne_digit.sv
// ----------------------------------------------------------------------------
// Roman numeral encoder digit unit
// Splits the leading decimal digit of the current place off the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_digit (
    input  var rne_pkg::t_num   i_rem,
    input  var rne_pkg::t_phase i_phase,
    output var rne_pkg::t_dig   o_dig
);
    import rne_pkg::*;

    t_digit d;

    always_comb begin
        d = '0;
        for (int k = 1; k <= 9; k++) begin
            if (i_rem >= place_mult(i_phase, 4'(k))) begin
                d = 4'(k);
            end
        end
    end

    always_comb begin
        o_dig.digit = d;
        o_dig.rem   = i_rem - place_mult(i_phase, d);
        o_dig.run   = (d >= 4'd5) ? 2'(d - 4'd5) : 2'(d);
    end

endmodule

`default_nettype wire

// File: dv/tb_roman_numeral_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Roman numeral encoder testbench
// Sends numbers through the start/busy handshake. Random burst gaps let the
// sender idle between items. Each number is turned into its
// expected symbol sequence on acceptance. Every strobed symbol is compared
// with the oldest expected one: symbol code, last flag and range error.
// ----------------------------------------------------------------------------
module tb_roman_numeral_encoder;
    import rne_pkg::*;

    typedef struct {
        t_sym sym;
        logic is_last;
        logic out_of_range;
    } t_numeral_sym;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_num i_number_in;
    logic o_strobe;
    t_sym o_symbol;
    logic o_last_symbol;
    logic o_out_of_range;

    t_numeral_sym expected_symbols[$];
    int mismatches = 0;
    int symbols_checked = 0;
    int numbers_sent = 0;
    int numbers_rejected = 0;
    int burst_left = 0;
    bit gaps_on = 1'b0;

    roman_numeral_encoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_number_in    (i_number_in),
        .o_strobe       (o_strobe),
        .o_symbol       (o_symbol),
        .o_last_symbol  (o_last_symbol),
        .o_out_of_range (o_out_of_range)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // expected numeral for one accepted number
    function automatic void predict_numeral(input t_num n);
        t_numeral_sym run[$];
        int remaining;
        int weight;
        int place;
        int digit;
        int k;
        t_sym one_s;
        t_sym five_s;
        t_sym ten_s;
        if (n == '0 || n >= LIMIT_HIGH) begin
            expected_symbols.push_back('{sym: SYM_I, is_last: 1'b1, out_of_range: 1'b1});
            return;
        end
        remaining = int'(n);
        weight = 1000;
        for (place = 3; place >= 0; place--) begin
            case (place)
                3: begin one_s = SYM_M; five_s = SYM_VBAR; ten_s = SYM_M; end
                2: begin one_s = SYM_C; five_s = SYM_D;    ten_s = SYM_M; end
                1: begin one_s = SYM_X; five_s = SYM_L;    ten_s = SYM_C; end
                default: begin one_s = SYM_I; five_s = SYM_V; ten_s = SYM_X; end
            endcase
            digit = remaining / weight;
            if (digit > 9) digit = 9;
            remaining = remaining - digit * weight;
            if (digit == 9) begin
                run.push_back('{sym: one_s, is_last: 1'b0, out_of_range: 1'b0});
                run.push_back('{sym: ten_s, is_last: 1'b0, out_of_range: 1'b0});
            end else if (digit >= 5) begin
                run.push_back('{sym: five_s, is_last: 1'b0, out_of_range: 1'b0});
                for (k = 5; k < digit; k++)
                    run.push_back('{sym: one_s, is_last: 1'b0, out_of_range: 1'b0});
            end else if (digit == 4) begin
                run.push_back('{sym: one_s, is_last: 1'b0, out_of_range: 1'b0});
                run.push_back('{sym: five_s, is_last: 1'b0, out_of_range: 1'b0});
            end else begin
                for (k = 0; k < digit; k++)
                    run.push_back('{sym: one_s, is_last: 1'b0, out_of_range: 1'b0});
            end
            weight = weight / 10;
        end
        run[run.size()-1].is_last = 1'b1;
        foreach (run[i]) expected_symbols.push_back(run[i]);
    endfunction

    function automatic t_num pick_number(input int invalid_pct);
        int r;
        int v;
        r = $urandom_range(99, 0);
        if (r < invalid_pct) begin
            if ($urandom_range(3, 0) == 0) return '0;
            return t_num'($urandom_range(16383, 9000));
        end
        if (r % 2 == 0) return t_num'($urandom_range(8999, 1));
        // digit-wise build reaches the long runs and subtractive forms more often
        v = $urandom_range(8, 0) * 1000 + $urandom_range(9, 0) * 100
            + $urandom_range(9, 0) * 10 + $urandom_range(9, 0);
        if (v == 0) v = 8888;
        return t_num'(v);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_number(input t_num n);
        if (gaps_on) begin
            if (burst_left == 0) begin
                start = 1'b0;
                repeat ($urandom_range(12, 1)) @(negedge i_clk);
                burst_left = $urandom_range(10, 1);
            end
            burst_left--;
        end
        i_number_in = n;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_numeral(n);
        numbers_sent++;
        if (n == '0 || n >= LIMIT_HIGH) numbers_rejected++;
        @(negedge i_clk);
    endtask

    task automatic test_edge_values();
        t_num values[$];
        values = {14'd1, 14'd3, 14'd4, 14'd5, 14'd8, 14'd9, 14'd10, 14'd40, 14'd49,
                  14'd90, 14'd400, 14'd900, 14'd1994, 14'd3888, 14'd3999, 14'd4000,
                  14'd4999, 14'd5000, 14'd8000, 14'd8888, 14'd8999, 14'd0, 14'd9000,
                  14'd16383, 14'd7};
        gaps_on = 1'b0;
        foreach (values[i]) send_number(values[i]);
        start = 1'b0;
    endtask

    task automatic test_random_numbers();
        gaps_on = 1'b1;
        burst_left = 0;
        repeat (200) send_number(pick_number(5));
        start = 1'b0;
    endtask

    // back to back, with range errors followed at once by further items
    task automatic test_streaming();
        gaps_on = 1'b0;
        repeat (60) send_number(pick_number(30));
        start = 1'b0;
    endtask

    task automatic test_range_errors();
        gaps_on = 1'b1;
        burst_left = 0;
        repeat (50) send_number(pick_number(60));
        start = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_numeral_sym e;
        bit unexpected;
        if (i_rst_n && o_strobe) begin
            symbols_checked++;
            unexpected = (expected_symbols.size() == 0);
            if (!unexpected) e = expected_symbols.pop_front();
            if (unexpected || o_symbol !== e.sym || o_last_symbol !== e.is_last
                    || o_out_of_range !== e.out_of_range) begin
                mismatches++;
                if (mismatches <= 10) begin
                    if (unexpected)
                        $display("%0t: unexpected symbol sym=%0d last=%b oor=%b",
                                 $realtime, o_symbol, o_last_symbol, o_out_of_range);
                    else
                        $display("%0t: expected sym=%0d last=%b oor=%b, got sym=%0d last=%b oor=%b",
                                 $realtime, e.sym, e.is_last, e.out_of_range,
                                 o_symbol, o_last_symbol, o_out_of_range);
                end
            end
        end
    end

    initial begin
        int drain_cycles;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_number_in = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_values();
        test_random_numbers();
        test_streaming();
        test_range_errors();

        drain_cycles = 0;
        while (expected_symbols.size() != 0 && drain_cycles < 2000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (30) @(posedge i_clk);

        if (expected_symbols.size() != 0)
            $display("%0d expected symbols never arrived", expected_symbols.size());
        $display("Encoded %0d numbers, %0d of them out of range; %0d symbols checked.",
                 numbers_sent, numbers_rejected, symbols_checked);
        $display("Covered edge values, random bursts with gaps, back-to-back items.");
        if (mismatches == 0 && expected_symbols.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
